>>> hdl/sbd_pkg.sv
// shared types and constants for the sector block device register block
// no dependencies; used by sbd_front, sbd_queue, sbd_back and the top level
package sbd_pkg;

  // register select codes on the byte bus
  localparam logic [2:0] SEL_LBA_LO = 3'd0;
  localparam logic [2:0] SEL_LBA_HI = 3'd1;
  localparam logic [2:0] SEL_STATUS = 3'd2;
  localparam logic [2:0] SEL_DATA   = 3'd3;
  localparam logic [2:0] SEL_CMD    = 3'd4;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // configuration register index (paddr bit 2)
  localparam logic REG_READ_CMD  = 1'b0;
  localparam logic REG_WRITE_CMD = 1'b1;

  // device status values
  localparam logic STATUS_READY = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // classified operations
  typedef enum logic [3:0] {
    OP_NOP       = 4'd0,
    OP_RD_LBA_LO = 4'd1,
    OP_RD_LBA_HI = 4'd2,
    OP_RD_STATUS = 4'd3,
    OP_RD_DATA   = 4'd4,
    OP_WR_LBA_LO = 4'd5,
    OP_WR_LBA_HI = 4'd6,
    OP_WR_DATA   = 4'd7,
    OP_LOAD      = 4'd8,
    OP_STORE     = 4'd9
  } op_code_t;

  typedef struct packed {
    op_code_t    op;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hdl/sbd_front.sv
// front end: apb command registers, request handshake and classification
// depends on sbd_pkg
module sbd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [2:0]           reg_select,
  input  logic [7:0]           write_byte,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  sbd_pkg::q_status_t   q_status,
  input  logic                 clearing,
  output logic                 push,
  output sbd_pkg::req_t        req
);

  logic [7:0] read_command;
  logic [7:0] write_command;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_command  <= 8'd1;
      write_command <= 8'd2;
    end else if (cfg_wr) begin
      if (paddr[2] == sbd_pkg::REG_READ_CMD) begin
        read_command <= pwdata[7:0];
      end else begin
        write_command <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == sbd_pkg::REG_READ_CMD) begin
      prdata = {24'd0, read_command};
    end else begin
      prdata = {24'd0, write_command};
    end
  end

  assign busy = clearing | q_status.full;
  assign push = start & ~busy;

  // classify the bus access; command bytes are matched here
  always_comb begin
    req.data = write_byte;
    req.op   = sbd_pkg::OP_NOP;
    if (kind == sbd_pkg::KIND_READ) begin
      unique case (reg_select)
        sbd_pkg::SEL_LBA_LO: req.op = sbd_pkg::OP_RD_LBA_LO;
        sbd_pkg::SEL_LBA_HI: req.op = sbd_pkg::OP_RD_LBA_HI;
        sbd_pkg::SEL_STATUS: req.op = sbd_pkg::OP_RD_STATUS;
        sbd_pkg::SEL_DATA:   req.op = sbd_pkg::OP_RD_DATA;
        default:             req.op = sbd_pkg::OP_NOP;
      endcase
    end else begin
      unique case (reg_select)
        sbd_pkg::SEL_LBA_LO: req.op = sbd_pkg::OP_WR_LBA_LO;
        sbd_pkg::SEL_LBA_HI: req.op = sbd_pkg::OP_WR_LBA_HI;
        sbd_pkg::SEL_DATA:   req.op = sbd_pkg::OP_WR_DATA;
        sbd_pkg::SEL_CMD: begin
          // read command wins when both bytes match
          if (write_byte == read_command) begin
            req.op = sbd_pkg::OP_LOAD;
          end else if (write_byte == write_command) begin
            req.op = sbd_pkg::OP_STORE;
          end else begin
            req.op = sbd_pkg::OP_NOP;
          end
        end
        default:             req.op = sbd_pkg::OP_NOP;
      endcase
    end
  end

endmodule

>>> hdl/sbd_queue.sv
// two-entry request queue between the front end and the back end
// depends on sbd_pkg
module sbd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sbd_pkg::req_t        req,
  input  logic                 pop,
  output sbd_pkg::req_t        head,
  output sbd_pkg::q_status_t   q_status
);

  sbd_pkg::req_t                  entries [sbd_pkg::QUEUE_DEPTH];
  logic [sbd_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sbd_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sbd_pkg::QCNT_W-1:0]     count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == sbd_pkg::QCNT_W'(sbd_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/sbd_back.sv
// back end: lba, pointer, status, sector buffer and disk store, sector copy engine
// depends on sbd_pkg; fed by sbd_queue
module sbd_back #(
  parameter int SECTOR_BYTES = 512,
  parameter int DISK_SECTORS = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sbd_pkg::req_t        head,
  input  sbd_pkg::q_status_t   q_status,
  output logic                 pop,
  output logic                 clearing,
  output logic                 done,
  output logic [7:0]           read_byte
);

  localparam int DISK_BYTES = DISK_SECTORS * SECTOR_BYTES;
  localparam int DISK_AW    = (DISK_BYTES > 1) ? $clog2(DISK_BYTES) : 1;
  localparam int PTR_W      = $clog2(SECTOR_BYTES);
  localparam int IDX_W      = $clog2(SECTOR_BYTES + 1);

  typedef enum logic [4:0] {
    S_CLEAR   = 5'b00001,
    S_IDLE    = 5'b00010,
    S_RD_DATA = 5'b00100,
    S_LOAD    = 5'b01000,
    S_STORE   = 5'b10000
  } state_t;

  state_t             state;
  logic [15:0]        block_address;
  logic [PTR_W-1:0]   buffer_pointer;
  logic [PTR_W-1:0]   pointer_next;
  logic               device_status;
  logic [DISK_AW-1:0] clr_addr;
  logic [DISK_AW-1:0] base;
  logic               in_range;
  logic               in_range_now;
  logic [IDX_W-1:0]   idx;
  logic               idx_end;
  logic               pend;
  logic [PTR_W-1:0]   pend_idx;

  logic [7:0]         buf_mem [SECTOR_BYTES];
  logic [7:0]         disk_mem [DISK_BYTES];
  logic [7:0]         buf_q;
  logic [7:0]         disk_q;

  logic               buf_we;
  logic [PTR_W-1:0]   buf_waddr;
  logic [7:0]         buf_wdata;
  logic               buf_re;
  logic [PTR_W-1:0]   buf_raddr;
  logic               disk_we;
  logic [DISK_AW-1:0] disk_waddr;
  logic [7:0]         disk_wdata;
  logic               disk_re;
  logic [DISK_AW-1:0] disk_raddr;

  assign clearing     = (state == S_CLEAR);
  assign pop          = (state == S_IDLE) && !q_status.empty;
  assign in_range_now = {1'b0, block_address} < 17'(DISK_SECTORS);
  assign idx_end      = (idx == IDX_W'(SECTOR_BYTES));
  assign pointer_next = (buffer_pointer == PTR_W'(SECTOR_BYTES - 1)) ? '0
                      : buffer_pointer + 1'b1;

  // memory port control
  always_comb begin
    buf_we     = 1'b0;
    buf_waddr  = buffer_pointer;
    buf_wdata  = head.data;
    buf_re     = 1'b0;
    buf_raddr  = buffer_pointer;
    disk_we    = 1'b0;
    disk_waddr = clr_addr;
    disk_wdata = 8'd0;
    disk_re    = 1'b0;
    disk_raddr = base + DISK_AW'(idx);
    unique case (state)
      S_CLEAR: begin
        disk_we   = 1'b1;
        buf_we    = {1'b0, clr_addr} < (DISK_AW + 1)'(SECTOR_BYTES);
        buf_waddr = clr_addr[PTR_W-1:0];
        buf_wdata = 8'd0;
      end
      S_IDLE: begin
        if (pop) begin
          buf_we = (head.op == sbd_pkg::OP_WR_DATA);
          buf_re = (head.op == sbd_pkg::OP_RD_DATA);
        end
      end
      S_RD_DATA: begin
      end
      S_LOAD: begin
        disk_re   = !idx_end;
        buf_we    = pend;
        buf_waddr = pend_idx;
        buf_wdata = in_range ? disk_q : 8'd0;
      end
      S_STORE: begin
        buf_re     = !idx_end;
        buf_raddr  = idx[PTR_W-1:0];
        disk_we    = pend;
        disk_waddr = base + DISK_AW'(pend_idx);
        disk_wdata = buf_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    if (buf_re) begin
      buf_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (disk_we) begin
      disk_mem[disk_waddr] <= disk_wdata;
    end
    if (disk_re) begin
      disk_q <= disk_mem[disk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_addr       <= '0;
      block_address  <= '0;
      buffer_pointer <= '0;
      device_status  <= sbd_pkg::STATUS_READY;
      done           <= 1'b0;
      pend           <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == DISK_AW'(DISK_BYTES - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (pop) begin
            read_byte <= 8'd0;
            case (head.op)
              sbd_pkg::OP_RD_LBA_LO: begin
                done      <= 1'b1;
                read_byte <= block_address[7:0];
              end
              sbd_pkg::OP_RD_LBA_HI: begin
                done      <= 1'b1;
                read_byte <= block_address[15:8];
              end
              sbd_pkg::OP_RD_STATUS: begin
                done      <= 1'b1;
                read_byte <= {7'd0, device_status};
              end
              sbd_pkg::OP_RD_DATA: begin
                buffer_pointer <= pointer_next;
                state          <= S_RD_DATA;
              end
              sbd_pkg::OP_WR_LBA_LO: begin
                done               <= 1'b1;
                block_address[7:0] <= head.data;
                buffer_pointer     <= '0;
              end
              sbd_pkg::OP_WR_LBA_HI: begin
                done                <= 1'b1;
                block_address[15:8] <= head.data;
                buffer_pointer      <= '0;
              end
              sbd_pkg::OP_WR_DATA: begin
                done           <= 1'b1;
                buffer_pointer <= pointer_next;
              end
              sbd_pkg::OP_LOAD: begin
                base           <= DISK_AW'(32'(block_address) * 32'(SECTOR_BYTES));
                in_range       <= in_range_now;
                idx            <= '0;
                pend           <= 1'b0;
                buffer_pointer <= '0;
                device_status  <= sbd_pkg::STATUS_READY;
                state          <= S_LOAD;
              end
              sbd_pkg::OP_STORE: begin
                if (in_range_now) begin
                  base          <= DISK_AW'(32'(block_address) * 32'(SECTOR_BYTES));
                  in_range      <= 1'b1;
                  idx           <= '0;
                  pend          <= 1'b0;
                  device_status <= sbd_pkg::STATUS_READY;
                  state         <= S_STORE;
                end else begin
                  device_status <= sbd_pkg::STATUS_ERROR;
                  done          <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_RD_DATA: begin
          done      <= 1'b1;
          read_byte <= buf_q;
          state     <= S_IDLE;
        end
        S_LOAD, S_STORE: begin
          pend     <= !idx_end;
          pend_idx <= idx[PTR_W-1:0];
          if (!idx_end) begin
            idx <= idx + 1'b1;
          end else begin
            done      <= 1'b1;
            read_byte <= 8'd0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no result while the reset clearing pass runs
  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result strobe during clearing pass");

  // the buffer pointer never leaves the sector
  a_ptr_in_sector: assert property (@(posedge clk) disable iff (rst)
    buffer_pointer <= PTR_W'(SECTOR_BYTES - 1))
    else $error("buffer pointer past sector end");

  // a store past capacity flags error and finishes at once
  a_store_oob: assert property (@(posedge clk) disable iff (rst)
    (pop && head.op == sbd_pkg::OP_STORE && !in_range_now)
      |=> (device_status == sbd_pkg::STATUS_ERROR) && done && (state == S_IDLE))
    else $error("store past capacity not flagged");

  // a copy that ends returns to idle with a strobe
  a_copy_end: assert property (@(posedge clk) disable iff (rst)
    ((state == S_LOAD || state == S_STORE) && idx_end) |=> done && (state == S_IDLE))
    else $error("sector copy did not complete");

endmodule

>>> hdl/sector_block_device_registers.sv
// Sector block device register file. A host issues one byte-bus request per start
// pulse (accepted when start is high and busy low); every request returns exactly one
// result byte on read_byte, marked by done for a single cycle, which the receiver must
// take as it comes. Register requests (lba, status, data writes, unknown commands)
// are queued, then popped by the back end, which registers done and the result; data
// reads pass through the buffer read and S_RD_DATA first. A read or write command walks
// the whole sector through the copy engine, one byte per cycle on the disk store port,
// and then returns to idle with its done strobe; a write command to a block past
// capacity finishes as fast as a register request. A two-entry request queue lets the
// host keep issuing while a sector copy runs; busy rises when it is full. After reset
// busy stays high while the disk store and the sector buffer are cleared one byte per
// cycle; the apb command registers can be written throughout.
// depends on sbd_pkg, sbd_front, sbd_queue and sbd_back
module sector_block_device_registers #(
  parameter int SECTOR_BYTES = 512,
  parameter int DISK_SECTORS = 128
) (
  input  logic        clk,
  input  logic        rst,
  // request port
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [2:0]  reg_select,
  input  logic [7:0]  write_byte,
  // result port
  output logic        done,
  output logic [7:0]  read_byte,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sbd_pkg::req_t      req;
  sbd_pkg::req_t      head;
  sbd_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic               clearing;

  // front end: handshake, command match, apb registers
  sbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .reg_select (reg_select),
    .write_byte (write_byte),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_status   (q_status),
    .clearing   (clearing),
    .push       (push),
    .req        (req)
  );

  // classified requests wait here while the back end copies a sector
  sbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // back end: register state, sector buffer, disk store and copy engine
  sbd_back #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .DISK_SECTORS (DISK_SECTORS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .read_byte (read_byte)
  );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for sector_block_device_registers: byte-bus requests,
// apb command registers and sector copies checked against an in-bench predictor
// depends on sbd_pkg and the sector_block_device_registers top level
`timescale 1ns / 100ps

module tb;

  localparam int SECTOR_BYTES = 512;
  localparam int DISK_SECTORS = 128;
  localparam int DISK_BYTES   = SECTOR_BYTES * DISK_SECTORS;

  // the clearing pass after reset alone keeps busy high while every disk byte is cleared,
  // so the watchdog limit on cycles with nothing moving is a multiple of DISK_BYTES
  localparam int STALL_LIMIT  = 4 * DISK_BYTES;
  localparam int REPORT_LIMIT = 10;

  // selector codes that no register answers to
  localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
  localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        kind;
  logic [2:0]  reg_select;
  logic [7:0]  write_byte;
  logic        done;
  logic [7:0]  read_byte;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sector_block_device_registers #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .DISK_SECTORS(DISK_SECTORS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .reg_select(reg_select),
    .write_byte(write_byte),
    .done(done),
    .read_byte(read_byte),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // device model: command bytes, block address, pointer, status, buffer, disk
  // ---------------------------------------------------------------------------
  logic [7:0]  load_cmd_model;
  logic [7:0]  store_cmd_model;
  logic [15:0] lba_model;
  int          ptr_model;
  logic        status_model;
  logic [7:0]  sector_model [SECTOR_BYTES];
  logic [7:0]  disk_model [DISK_BYTES];

  // read_byte values still owed by the block, oldest first
  logic [7:0]  expected_bytes [$];

  int fail_count;
  int requests_sent;
  int sector_cmd_count;
  int settings_count;
  int no_idle_run;
  int stall_cycles;

  task automatic reset_models();
    load_cmd_model  = 8'd1;
    store_cmd_model = 8'd2;
    lba_model       = '0;
    ptr_model       = 0;
    status_model    = sbd_pkg::STATUS_READY;
    foreach (sector_model[i]) sector_model[i] = 8'h00;
    foreach (disk_model[i]) disk_model[i] = 8'h00;
  endtask

  // advances the device model by one request and returns the byte it answers
  function automatic logic [7:0] predict_read_byte(logic k, logic [2:0] sel, logic [7:0] b);
    logic [7:0] r;
    int         base;
    r    = 8'h00;
    base = int'(lba_model) * SECTOR_BYTES;
    if (k == sbd_pkg::KIND_READ) begin
      case (sel)
        sbd_pkg::SEL_LBA_LO: r = lba_model[7:0];
        sbd_pkg::SEL_LBA_HI: r = lba_model[15:8];
        sbd_pkg::SEL_STATUS: r = {7'd0, status_model};
        sbd_pkg::SEL_DATA: begin
          r         = sector_model[ptr_model];
          ptr_model = (ptr_model + 1) % SECTOR_BYTES;
        end
        default: r = 8'h00;
      endcase
    end else begin
      case (sel)
        sbd_pkg::SEL_LBA_LO: begin
          lba_model[7:0] = b;
          ptr_model      = 0;
        end
        sbd_pkg::SEL_LBA_HI: begin
          lba_model[15:8] = b;
          ptr_model       = 0;
        end
        sbd_pkg::SEL_DATA: begin
          sector_model[ptr_model] = b;
          ptr_model               = (ptr_model + 1) % SECTOR_BYTES;
        end
        sbd_pkg::SEL_CMD: begin
          // load wins when both command bytes match
          if (b == load_cmd_model) begin
            sector_cmd_count++;
            ptr_model = 0;
            for (int i = 0; i < SECTOR_BYTES; i++)
              sector_model[i] = (int'(lba_model) < DISK_SECTORS) ? disk_model[base + i] : 8'h00;
            status_model = sbd_pkg::STATUS_READY;
          end else if (b == store_cmd_model) begin
            sector_cmd_count++;
            if (int'(lba_model) < DISK_SECTORS) begin
              for (int i = 0; i < SECTOR_BYTES; i++) disk_model[base + i] = sector_model[i];
              status_model = sbd_pkg::STATUS_READY;
            end else begin
              status_model = sbd_pkg::STATUS_ERROR;
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic note_failure(string what, logic [7:0] want, logic [7:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s expected %02h actual %02h", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // request side: random hold-off, then start held until busy is seen low
  // ---------------------------------------------------------------------------
  task automatic send_request(logic k, logic [2:0] sel, logic [7:0] b);
    int gap;
    if (no_idle_run > 0) begin
      gap = 0;
      no_idle_run--;
    end else begin
      gap = $urandom_range(0, 16);
      // now and then a run of back-to-back requests
      if ($urandom_range(0, 39) == 0) no_idle_run = $urandom_range(8, 48);
    end
    // start only drops when a real gap follows, so a held start never glitches
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    kind       <= k;
    reg_select <= sel;
    write_byte <= b;
    do @(posedge clk); while (busy);
    expected_bytes.push_back(predict_read_byte(k, sel, b));
    requests_sent++;
  endtask

  // stop issuing and let every owed result come back
  task automatic drain_requests();
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // one apb transfer; psel is left high so a second transfer can follow directly
  task automatic apb_transfer(logic wr, logic idx, logic [31:0] data, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  // write a command register, read it back, and track it in the model
  task automatic set_command_register(logic idx, logic [7:0] value);
    logic [31:0] rdata;
    @(posedge clk);
    // the top half carries noise; only the low byte is the register
    apb_transfer(1'b1, idx, {16'($urandom_range(0, 16'hFFFF)), 8'h00, value}, rdata);
    if (idx == sbd_pkg::REG_READ_CMD) load_cmd_model = value;
    else store_cmd_model = value;
    apb_transfer(1'b0, idx, 32'h0, rdata);
    if (rdata[7:0] !== value) note_failure("command register readback", value, rdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_commands(logic [7:0] load_cmd, logic [7:0] store_cmd);
    set_command_register(sbd_pkg::REG_READ_CMD, load_cmd);
    set_command_register(sbd_pkg::REG_WRITE_CMD, store_cmd);
    settings_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: done cannot be held off, so every strobe is checked as it comes
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_bytes.size() == 0) note_failure("result with no request owed", 8'h00, read_byte);
      else begin
        logic [7:0] want;
        want = expected_bytes.pop_front();
        if (read_byte !== want) note_failure("read_byte", want, read_byte);
      end
    end
  end

  // watchdog: cycles in which neither a request nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // random traffic: mostly address/data/command sequences, some loose noise
  // ---------------------------------------------------------------------------
  task automatic pick_block_address();
    int         roll;
    logic [7:0] lo;
    logic [7:0] hi;
    roll = $urandom_range(0, 9);
    hi   = 8'h00;
    // a few hot sectors at both ends of the disk so stored data gets read back
    if (roll < 6) lo = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(124, 127));
    else lo = 8'($urandom_range(0, 255));
    if (roll == 9) hi = 8'($urandom_range(0, 255));
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_LO, lo);
    if (roll >= 8 || $urandom_range(0, 1)) send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_HI, hi);
  endtask

  task automatic run_random_traffic(int count);
    int         goal;
    int         roll;
    int         len;
    logic [2:0] sel;
    logic [7:0] b;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      roll = $urandom_range(0, 99);
      len  = $urandom_range(1, 24);
      if (roll < 30) begin
        // fill part of the buffer and store it
        pick_block_address();
        repeat (len)
          send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
        send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, store_cmd_model);
        send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_STATUS, 8'($urandom_range(0, 255)));
      end else if (roll < 60) begin
        // load a sector and walk into it
        pick_block_address();
        send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, load_cmd_model);
        repeat (len)
          send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
        send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_STATUS, 8'($urandom_range(0, 255)));
      end else begin
        sel = 3'($urandom_range(0, 7));
        b   = 8'($urandom_range(0, 255));
        if (sel == sbd_pkg::SEL_CMD && $urandom_range(0, 1))
          b = $urandom_range(0, 1) ? load_cmd_model : store_cmd_model;
        send_request(1'($urandom_range(0, 1)), sel, b);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every register both ways, field extremes, spare selectors, capacity edges
  task automatic test_directed();
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_LBA_LO, 8'hFF);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_LBA_HI, 8'h00);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_STATUS, 8'h00);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_CMD, 8'h00);
    send_request(sbd_pkg::KIND_READ, SEL_SPARE_LAST, 8'hFF);
    // spare selector and status writes change nothing
    send_request(sbd_pkg::KIND_WRITE, SEL_SPARE_FIRST, 8'hFF);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_STATUS, 8'hFF);
    // last sector inside capacity
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_LO, 8'h7F);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_HI, 8'h00);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_LBA_LO, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'hFF);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'hA5);
    // unknown command byte is dropped
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, 8'h00);
    // store keeps the pointer, load rewinds it
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, store_cmd_model);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, load_cmd_model);
    repeat (3) send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    // past capacity: store flags an error, load gives zeros and clears it
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_HI, 8'hFF);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_LBA_HI, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, store_cmd_model);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_STATUS, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, load_cmd_model);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_STATUS, 8'h00);
    send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    drain_requests();
  endtask

  // write and read a little more than a sector so the pointer wraps both ways
  task automatic test_pointer_wrap();
    set_commands(8'hFF, 8'h00);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_LO,
                 8'($urandom_range(0, DISK_SECTORS - 1)));
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_HI, 8'h00);
    repeat (SECTOR_BYTES + 3)
      send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, store_cmd_model);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, load_cmd_model);
    repeat (SECTOR_BYTES + 3) send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    drain_requests();
  endtask

  // one byte matches both commands: it must load, never store
  task automatic test_equal_commands();
    logic [7:0] same;
    same = 8'($urandom_range(1, 254));
    set_commands(same, same);
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_LBA_LO, 8'h02);
    repeat (4)
      send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_DATA, 8'($urandom_range(0, 255)));
    send_request(sbd_pkg::KIND_WRITE, sbd_pkg::SEL_CMD, same);
    repeat (4) send_request(sbd_pkg::KIND_READ, sbd_pkg::SEL_DATA, 8'h00);
    run_random_traffic(300);
    drain_requests();
  endtask

  task automatic test_swapped_extremes();
    set_commands(8'h00, 8'hFF);
    run_random_traffic(300);
    drain_requests();
  endtask

  task automatic test_random_commands();
    logic [7:0] load_cmd;
    logic [7:0] store_cmd;
    load_cmd = 8'($urandom_range(0, 255));
    do store_cmd = 8'($urandom_range(0, 255)); while (store_cmd == load_cmd);
    set_commands(load_cmd, store_cmd);
    run_random_traffic(200);
    drain_requests();
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    start            <= 1'b0;
    kind             <= sbd_pkg::KIND_READ;
    reg_select       <= sbd_pkg::SEL_LBA_LO;
    write_byte       <= 8'h00;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    fail_count       = 0;
    requests_sent    = 0;
    sector_cmd_count = 0;
    settings_count   = 1;
    no_idle_run      = 0;
    reset_models();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // the block spends its first stretch clearing the disk; requests simply wait
    test_directed();
    test_pointer_wrap();
    test_equal_commands();
    test_swapped_extremes();
    test_random_commands();

    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) note_failure("results never returned", 8'h00, 8'h00);

    $display("covered %0d requests, %0d sector commands, %0d command settings",
             requests_sent, sector_cmd_count, settings_count);
    $display("failures: %0d", fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
